// ===== src/line_draw_into_frame_store_top_assert.svh =====
// Assertion macros for the line drawing engine checker.
// Used by ldfs_checker.sv; needs nothing else.
`ifndef LINE_DRAW_INTO_FRAME_STORE_TOP_ASSERT_SVH
`define LINE_DRAW_INTO_FRAME_STORE_TOP_ASSERT_SVH

// same-cycle implication, reset masks the check
`define LDFS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset masks the check
`define LDFS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ldfs_pkg.sv =====
// Shared constants and types of the line drawing engine.
// No dependencies; imported by every module of the block but ldfs_ram.
package ldfs_pkg;

  localparam int IMAGE_SIDE = 256;
  localparam int COORD_W    = 12;
  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;
  localparam int ERR_W      = COORD_W + 3;
  localparam int SIDE_W     = $clog2(IMAGE_SIDE);
  localparam int DEPTH      = IMAGE_SIDE * IMAGE_SIDE;
  localparam int ADDR_W     = $clog2(DEPTH);

  // item action codes
  localparam logic ACT_DRAW = 1'b0;
  localparam logic ACT_READ = 1'b1;

  // one step of the line walker, as seen by the store controller
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] addr;
    logic              done;
  } pix_t;

endpackage

// ===== src/ldfs_ram.sv =====
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
module ldfs_ram #(
  parameter int DW = 24,
  parameter int AW = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          re,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [0:(2**AW)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/ldfs_walker.sv =====
// Error-term line walker: one point per cycle, clip and row flip, store address.
// Depends on ldfs_pkg.
module ldfs_walker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                load,
  input  logic signed [ldfs_pkg::COORD_W-1:0] x0,
  input  logic signed [ldfs_pkg::COORD_W-1:0] y0,
  input  logic signed [ldfs_pkg::COORD_W-1:0] x1,
  input  logic signed [ldfs_pkg::COORD_W-1:0] y1,
  output ldfs_pkg::pix_t                      pix
);
  import ldfs_pkg::*;

  localparam logic signed [ERR_W-1:0] SIDE_S = ERR_W'(IMAGE_SIDE);
  localparam logic signed [ERR_W-1:0] TOP_S  = ERR_W'(IMAGE_SIDE - 1);

  logic signed [COORD_W-1:0] x_r, y_r, xe_r, ye_r, x_nxt, y_nxt;
  logic signed [ERR_W-1:0]   dx_r, dy_r, err_r, dx_nxt, dy_nxt, err_nxt;
  logic                      xneg_r, yneg_r, active_r, active_nxt;

  logic signed [ERR_W-1:0]   ddx, ddy, e2, xw, row;
  logic                      at_end, go_x, go_y, in_frame;

  always_comb begin
    ddx = ERR_W'(x1) - ERR_W'(x0);
    ddy = ERR_W'(y1) - ERR_W'(y0);
    e2  = err_r <<< 1;
    go_x = e2 > -dy_r;
    go_y = e2 < dx_r;
    at_end = (x_r == xe_r) && (y_r == ye_r);

    xw  = ERR_W'(x_r);
    row = TOP_S - ERR_W'(y_r);
    in_frame = (xw >= 0) && (xw < SIDE_S) && (row >= 0) && (row < SIDE_S);

    // default: hold
    x_nxt      = x_r;
    y_nxt      = y_r;
    dx_nxt     = dx_r;
    dy_nxt     = dy_r;
    err_nxt    = err_r;
    active_nxt = active_r;

    if (load) begin
      x_nxt      = x0;
      y_nxt      = y0;
      dx_nxt     = (ddx < 0) ? -ddx : ddx;
      dy_nxt     = (ddy < 0) ? -ddy : ddy;
      err_nxt    = dx_nxt - dy_nxt;
      active_nxt = 1'b1;
    end else if (active_r) begin
      if (at_end) begin
        active_nxt = 1'b0;
      end else begin
        err_nxt = err_r - (go_x ? dy_r : '0) + (go_y ? dx_r : '0);
        if (go_x) begin
          x_nxt = xneg_r ? x_r - COORD_W'(1) : x_r + COORD_W'(1);
        end
        if (go_y) begin
          y_nxt = yneg_r ? y_r - COORD_W'(1) : y_r + COORD_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    dx_r  <= dx_nxt;
    dy_r  <= dy_nxt;
    err_r <= err_nxt;
    if (load) begin
      xe_r   <= x1;
      ye_r   <= y1;
      xneg_r <= !(x0 < x1);
      yneg_r <= !(y0 < y1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
  end

  assign pix.wr_en = active_r && in_frame;
  assign pix.addr  = ADDR_W'(row[SIDE_W-1:0]) * ADDR_W'(IMAGE_SIDE)
                   + ADDR_W'(xw[SIDE_W-1:0]);
  assign pix.done  = active_r && at_end;

endmodule

// ===== src/line_draw_into_frame_store_top.sv =====
// Line drawing engine over a square 24-bit RGB frame store: top level.
// Depends on ldfs_pkg, ldfs_ram and ldfs_walker.
//
// After reset the block holds busy high while it clears all IMAGE_SIDE*IMAGE_SIDE
// pixels of the store (65536 at side 256) to black, one pixel a cycle.
// An item is taken when start is high and busy is low. A draw item walks the
// line one point per cycle through the walker and the store's write port, so
// it keeps busy high until the last point and its result strobe comes in the
// cycle after the last point, with busy already low. A read item keeps
// busy high for one cycle: the store's registered read port fetches at the
// accepting edge and the pixel is presented in the next cycle. Every item
// gives exactly one result, shown for one cycle with
// out_valid high; the receiver cannot stall, so it must take it then. Points
// outside the frame are skipped; a draw result carries zero colour.
module line_draw_into_frame_store_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_action,
  input  logic signed [ldfs_pkg::COORD_W-1:0] in_start_x,
  input  logic signed [ldfs_pkg::COORD_W-1:0] in_start_y,
  input  logic signed [ldfs_pkg::COORD_W-1:0] in_end_x,
  input  logic signed [ldfs_pkg::COORD_W-1:0] in_end_y,
  input  logic [ldfs_pkg::CH_W-1:0]           in_red_in,
  input  logic [ldfs_pkg::CH_W-1:0]           in_green_in,
  input  logic [ldfs_pkg::CH_W-1:0]           in_blue_in,
  input  logic [ldfs_pkg::CH_W-1:0]           in_read_row,
  input  logic [ldfs_pkg::CH_W-1:0]           in_read_col,
  output logic                                out_valid,
  output logic                                out_is_read_result,
  output logic [ldfs_pkg::CH_W-1:0]           out_red_out,
  output logic [ldfs_pkg::CH_W-1:0]           out_green_out,
  output logic [ldfs_pkg::CH_W-1:0]           out_blue_out
);
  import ldfs_pkg::*;

  // controller states
  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_DRAW  = 2'd2;
  localparam logic [1:0] ST_RDOUT = 2'd3;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  logic [1:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  logic              done_r;
  logic              inrange_r;
  logic [PIX_W-1:0]  colour_r;

  logic              accept, load, rd_en, rd_inrange;
  logic [ADDR_W-1:0] rd_addr;
  pix_t              pix;

  logic              we;
  logic [ADDR_W-1:0] wr_addr;
  logic [PIX_W-1:0]  wr_data, rd_data;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign load   = accept && (in_action == ACT_DRAW);
  assign rd_en  = accept && (in_action != ACT_DRAW);

  // reads past the frame give black; the read data is only passed on when in range
  assign rd_inrange = (32'(in_read_row) < IMAGE_SIDE) && (32'(in_read_col) < IMAGE_SIDE);
  assign rd_addr    = ADDR_W'(in_read_row) * ADDR_W'(IMAGE_SIDE) + ADDR_W'(in_read_col);

  ldfs_walker u_walker (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (load),
    .x0    (in_start_x),
    .y0    (in_start_y),
    .x1    (in_end_x),
    .y1    (in_end_y),
    .pix   (pix)
  );

  // write port: clearing sweep after reset, walker points otherwise
  always_comb begin
    if (state_r == ST_CLEAR) begin
      we      = 1'b1;
      wr_addr = clr_r;
      wr_data = '0;
    end else begin
      we      = pix.wr_en;
      wr_addr = pix.addr;
      wr_data = colour_r;
    end
  end

  ldfs_ram #(
    .DW (PIX_W),
    .AW (ADDR_W)
  ) u_store (
    .clk     (clk),
    .we      (we),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .re      (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + ADDR_W'(1);
        if (clr_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (load) begin
          state_nxt = ST_DRAW;
        end else if (rd_en) begin
          state_nxt = ST_RDOUT;
        end
      end
      ST_DRAW: begin
        if (pix.done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RDOUT: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      done_r  <= pix.done;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      colour_r <= {in_red_in, in_green_in, in_blue_in};
    end
    if (rd_en) begin
      inrange_r <= rd_inrange;
    end
  end

  // result: read data in the output state, line-done strobe in the cycle after
  // the last point was written
  always_comb begin
    out_valid          = done_r || (state_r == ST_RDOUT);
    out_is_read_result = (state_r == ST_RDOUT);
    {out_red_out, out_green_out, out_blue_out} = '0;
    if ((state_r == ST_RDOUT) && inrange_r) begin
      {out_red_out, out_green_out, out_blue_out} = rd_data;
    end
  end

endmodule

// ===== src/ldfs_checker.sv =====
// Port-level checker for the line drawing engine, bound to the top level.
// Depends on ldfs_pkg and line_draw_into_frame_store_top_assert.svh.
`include "line_draw_into_frame_store_top_assert.svh"

module ldfs_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic                      in_action,
  input logic                      out_valid,
  input logic                      out_is_read_result,
  input logic [ldfs_pkg::CH_W-1:0] out_red_out,
  input logic [ldfs_pkg::CH_W-1:0] out_green_out,
  input logic [ldfs_pkg::CH_W-1:0] out_blue_out
);
  import ldfs_pkg::*;

  // a read result is never directly followed by another result
  `LDFS_ASSERT_NEXT(a_strobe_single, out_valid && out_is_read_result, !out_valid,
                    "result strobe right after a read result")

  // a taken item always raises busy
  `LDFS_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy, "busy low after accept")

  // a read answers on the very next cycle
  `LDFS_ASSERT_NEXT(a_read_latency, start && !busy && in_action,
                    out_valid && out_is_read_result, "read result late")

  // line-done results carry no colour
  `LDFS_ASSERT_NOW(a_draw_black, out_valid && !out_is_read_result,
                   (out_red_out == '0) && (out_green_out == '0) && (out_blue_out == '0),
                   "draw result with colour")

endmodule

bind line_draw_into_frame_store_top ldfs_checker u_ldfs_checker (.*);

// ===== verif/line_draw_into_frame_store_top_tb.sv =====
// Self-checking bench for line_draw_into_frame_store_top: directed and random
// draw and read items, checked against a shadow frame held in the bench.
// Depends on ldfs_pkg and the RTL of the block.
module line_draw_into_frame_store_top_tb;
  import ldfs_pkg::*;

  // Slowest legal run: the store clearing pass, then ~1420 items. A
  // full-range line walks up to 4096 points, and 5% of random items are
  // full-range draws. The limit is set well above the worst case.
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int          DRAIN_CYCLES = 16;    // read data comes from the store's registered port
  localparam int          RECENT_MAX   = 256;   // pool of lit pixels for reads
  localparam int          RANDOM_ITEMS = 1400;

  typedef logic                      action_t;
  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [CH_W-1:0]           chan_t;

  // one item as the bench builds it; row and col only matter on a read
  typedef struct {
    action_t action;
    coord_t  start_x, start_y, end_x, end_y;
    chan_t   red, green, blue;
    chan_t   row, col;
  } pixel_cmd_t;

  typedef struct {
    logic  is_read;
    chan_t red, green, blue;
  } pixel_reply_t;

  logic   clk;
  logic   rst_n;
  logic   start;
  logic   busy;
  logic   in_action;
  coord_t in_start_x, in_start_y, in_end_x, in_end_y;
  chan_t  in_red_in, in_green_in, in_blue_in;
  chan_t  in_read_row, in_read_col;
  logic   out_valid;
  logic   out_is_read_result;
  chan_t  out_red_out, out_green_out, out_blue_out;

  line_draw_into_frame_store_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_action          (in_action),
    .in_start_x         (in_start_x),
    .in_start_y         (in_start_y),
    .in_end_x           (in_end_x),
    .in_end_y           (in_end_y),
    .in_red_in          (in_red_in),
    .in_green_in        (in_green_in),
    .in_blue_in         (in_blue_in),
    .in_read_row        (in_read_row),
    .in_read_col        (in_read_col),
    .out_valid          (out_valid),
    .out_is_read_result (out_is_read_result),
    .out_red_out        (out_red_out),
    .out_green_out      (out_green_out),
    .out_blue_out       (out_blue_out)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Shadow copy of the frame store, updated in item order at acceptance.
  logic [PIX_W-1:0] shadow_frame [DEPTH];
  int               recent_pixels [$];    // addresses of recently lit pixels
  pixel_reply_t     pending_replies [$];  // oldest expected result first
  int               max_gap     = 10;     // 0 gives back-to-back bursts
  int               error_count = 0;
  int unsigned      cycle_count = 0;

  // Store one line point; the y axis points up, so the row is flipped.
  // Points off the frame are dropped but the walk carries on.
  function automatic void plot_point(int x, int y, logic [PIX_W-1:0] colour);
    int row;
    row = IMAGE_SIDE - 1 - y;
    if (x < 0 || x >= IMAGE_SIDE || row < 0 || row >= IMAGE_SIDE) return;
    shadow_frame[row * IMAGE_SIDE + x] = colour;
    recent_pixels.push_back(row * IMAGE_SIDE + x);
    if (recent_pixels.size() > RECENT_MAX) void'(recent_pixels.pop_front());
  endfunction

  // Integer error-term walk, both end points included.
  function automatic void trace_line(int x, int y, int xe, int ye,
                                     logic [PIX_W-1:0] colour);
    int dx, dy, sx, sy, err, e2;
    dx  = (xe > x) ? xe - x : x - xe;
    dy  = (ye > y) ? ye - y : y - ye;
    sx  = (x < xe) ? 1 : -1;
    sy  = (y < ye) ? 1 : -1;
    err = dx - dy;
    while (1) begin
      plot_point(x, y, colour);
      if (x == xe && y == ye) break;
      e2 = 2 * err;
      if (e2 > -dy) begin
        err -= dy;
        x   += sx;
      end
      if (e2 < dx) begin
        err += dx;
        y   += sy;
      end
    end
  endfunction

  // Expected result of one item; a draw also updates the shadow frame.
  function automatic pixel_reply_t predict_reply(pixel_cmd_t cmd);
    pixel_reply_t     rep;
    logic [PIX_W-1:0] pix;
    pix         = '0;
    rep.is_read = (cmd.action == ACT_READ);
    if (cmd.action == ACT_DRAW)
      trace_line(cmd.start_x, cmd.start_y, cmd.end_x, cmd.end_y,
                 {cmd.red, cmd.green, cmd.blue});
    else if (int'(cmd.row) < IMAGE_SIDE && int'(cmd.col) < IMAGE_SIDE)
      pix = shadow_frame[int'(cmd.row) * IMAGE_SIDE + int'(cmd.col)];
    {rep.red, rep.green, rep.blue} = pix;
    return rep;
  endfunction

  // All fields random; callers overwrite the ones that matter.
  function automatic pixel_cmd_t random_fill();
    pixel_cmd_t cmd;
    cmd.action  = action_t'($urandom_range(0, 1));
    cmd.start_x = coord_t'($urandom);
    cmd.start_y = coord_t'($urandom);
    cmd.end_x   = coord_t'($urandom);
    cmd.end_y   = coord_t'($urandom);
    cmd.red     = chan_t'($urandom);
    cmd.green   = chan_t'($urandom);
    cmd.blue    = chan_t'($urandom);
    cmd.row     = chan_t'($urandom);
    cmd.col     = chan_t'($urandom);
    return cmd;
  endfunction

  // Present one item and hold it until the block takes it. start is left
  // high on return so a zero gap gives back-to-back items; only one
  // assignment to start happens per edge.
  task automatic send_item(pixel_cmd_t cmd);
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_action   <= cmd.action;
    in_start_x  <= cmd.start_x;
    in_start_y  <= cmd.start_y;
    in_end_x    <= cmd.end_x;
    in_end_y    <= cmd.end_y;
    in_red_in   <= cmd.red;
    in_green_in <= cmd.green;
    in_blue_in  <= cmd.blue;
    in_read_row <= cmd.row;
    in_read_col <= cmd.col;
    start       <= 1'b1;
    @(posedge clk);
    // busy is sampled as it was before this edge; X counts as busy
    while (busy !== 1'b0) @(posedge clk);
    pending_replies.push_back(predict_reply(cmd));
  endtask

  // Draw with random read fields, which the block must ignore.
  task automatic draw_item(int x0, int y0, int x1, int y1, chan_t r, chan_t g, chan_t b);
    pixel_cmd_t cmd;
    cmd         = random_fill();
    cmd.action  = ACT_DRAW;
    cmd.start_x = coord_t'(x0);
    cmd.start_y = coord_t'(y0);
    cmd.end_x   = coord_t'(x1);
    cmd.end_y   = coord_t'(y1);
    cmd.red     = r;
    cmd.green   = g;
    cmd.blue    = b;
    send_item(cmd);
  endtask

  // Read with random line fields, which the block must ignore.
  task automatic read_item(int row, int col);
    pixel_cmd_t cmd;
    cmd        = random_fill();
    cmd.action = ACT_READ;
    cmd.row    = chan_t'(row);
    cmd.col    = chan_t'(col);
    send_item(cmd);
  endtask

  // Corners read back black after the clearing pass.
  task automatic test_cleared_store();
    read_item(0, 0);
    read_item(0, IMAGE_SIDE - 1);
    read_item(IMAGE_SIDE - 1, 0);
    read_item(IMAGE_SIDE - 1, IMAGE_SIDE - 1);
  endtask

  // Start equal to end lights one pixel; y = 0 lands on the bottom row.
  task automatic test_single_points();
    draw_item(0, 0, 0, 0, 8'hff, 8'hff, 8'hff);
    draw_item(255, 255, 255, 255, 8'h00, 8'hff, 8'h00);
    read_item(255, 0);
    read_item(0, 255);
  endtask

  // Horizontal, steep, shallow-reversed and diagonal lines, each read at one point.
  task automatic test_line_shapes();
    draw_item(10, 100, 20, 100, 8'h11, 8'h22, 8'h33);
    draw_item(40, 60, 40, 30, 8'h80, 8'h01, 8'hfe);
    draw_item(250, 7, 200, 20, 8'h5a, 8'ha5, 8'h00);
    draw_item(100, 100, 90, 110, 8'h7f, 8'h80, 8'hc3);
    read_item(155, 15);
    read_item(255 - 45, 40);
    read_item(255 - 20, 200);
    read_item(255 - 110, 90);
  endtask

  // Lines reaching far off the frame: only the visible part is stored.
  task automatic test_clipping();
    draw_item(-2048, -2048, 2047, 2047, 8'h12, 8'h34, 8'h56);
    draw_item(2047, -2048, -2048, 2047, 8'hff, 8'h00, 8'hff);  // x+y = -1, all off
    draw_item(0, 256, 10, 256, 8'hee, 8'hee, 8'hee);           // flipped row -1
    draw_item(0, -1, 5, -1, 8'hdd, 8'hdd, 8'hdd);              // flipped row 256
    draw_item(250, 3, 270, 3, 8'h01, 8'h02, 8'h04);            // runs off the right
    read_item(127, 128);
    read_item(252, 255);
  endtask

  // Mostly short lines near the frame and reads of lit pixels, with some
  // frame-wide lines and full-range noise.
  task automatic test_random_traffic(int count);
    pixel_cmd_t cmd;
    int         kind, x0, y0, pick;
    for (int n = 0; n < count; n++) begin
      // every 40 items pick either free gaps or a burst with none
      if (n % 40 == 0) max_gap = ($urandom_range(0, 3) == 0) ? 0 : 10;
      cmd  = random_fill();
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        cmd.action  = ACT_DRAW;
        x0          = int'($urandom_range(0, 271)) - 8;
        y0          = int'($urandom_range(0, 271)) - 8;
        cmd.start_x = coord_t'(x0);
        cmd.start_y = coord_t'(y0);
        cmd.end_x   = coord_t'(x0 + int'($urandom_range(0, 80)) - 40);
        cmd.end_y   = coord_t'(y0 + int'($urandom_range(0, 80)) - 40);
      end else if (kind < 65) begin
        cmd.action  = ACT_DRAW;
        cmd.start_x = coord_t'(int'($urandom_range(0, 287)) - 16);
        cmd.start_y = coord_t'(int'($urandom_range(0, 287)) - 16);
        cmd.end_x   = coord_t'(int'($urandom_range(0, 287)) - 16);
        cmd.end_y   = coord_t'(int'($urandom_range(0, 287)) - 16);
      end else if (kind < 70) begin
        cmd.action = ACT_DRAW;  // full 12-bit coordinates from the fill
      end else begin
        cmd.action = ACT_READ;
        if ($urandom_range(0, 3) != 0 && recent_pixels.size() != 0) begin
          pick    = recent_pixels[$urandom_range(0, recent_pixels.size() - 1)];
          cmd.row = chan_t'(pick / IMAGE_SIDE);
          cmd.col = chan_t'(pick % IMAGE_SIDE);
        end
      end
      send_item(cmd);
    end
    max_gap = 10;
  endtask

  function automatic void check_field(string name, logic [CH_W-1:0] want,
                                      logic [CH_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  // Every strobe is matched against the oldest outstanding expectation.
  always @(posedge clk) begin : reply_checker
    pixel_reply_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_replies.size() == 0) begin
        $error("result strobe with no item outstanding");
        error_count++;
      end else begin
        want = pending_replies.pop_front();
        check_field("out_is_read_result", CH_W'(want.is_read), CH_W'(out_is_read_result));
        check_field("out_red_out", want.red, out_red_out);
        check_field("out_green_out", want.green, out_green_out);
        check_field("out_blue_out", want.blue, out_blue_out);
      end
    end
  end

  // Watchdog: a hung handshake or missing result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $error("timeout with %0d results outstanding", pending_replies.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst_n       <= 1'b0;
    start       <= 1'b0;
    in_action   <= ACT_DRAW;
    in_start_x  <= '0;
    in_start_y  <= '0;
    in_end_x    <= '0;
    in_end_y    <= '0;
    in_red_in   <= '0;
    in_green_in <= '0;
    in_blue_in  <= '0;
    in_read_row <= '0;
    in_read_col <= '0;
    foreach (shadow_frame[i]) shadow_frame[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    // first item simply waits out the clearing pass behind busy
    test_cleared_store();
    test_single_points();
    test_line_shapes();
    test_clipping();
    test_random_traffic(RANDOM_ITEMS);
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);  // catch any stray strobe
    if (error_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/ldfs_pkg.sv
src/ldfs_ram.sv
src/ldfs_walker.sv
src/line_draw_into_frame_store_top.sv
src/ldfs_checker.sv
verif/line_draw_into_frame_store_top_tb.sv
